// ===== hw/rtl/flash_ring_log_index_manager_assert.svh =====
// Assertion macros shared by the flash ring log index manager RTL.
// Define ASSERT_OFF to compile every assertion away; needs aclk and aresetn in scope.
`ifndef FLASH_RING_LOG_INDEX_MANAGER_ASSERT_SVH
`define FLASH_RING_LOG_INDEX_MANAGER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define FRLIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define FRLIM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FRLIM_ASSERT(lbl, prop, msg)
`define FRLIM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/frlim_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and the slot-to-sector function of the flash ring log index manager.
// No dependencies.
package frlim_pkg;

    localparam int unsigned CAPACITY     = 1398101;
    localparam int unsigned SECTOR_COUNT = 8192;
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned RECORD_BYTES = 24;

    localparam int SLOT_W = 21;
    localparam int SEC_W  = 13;
    localparam int SEQ_W  = 32;
    localparam int ACT_W  = 3;

    // Byte offset of a slot, and the sector number taken from it (one bit of headroom).
    localparam int PROD_W = SLOT_W + $clog2(RECORD_BYTES + 1);
    localparam int SECX_W = PROD_W - $clog2(SECTOR_BYTES);

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD     = 3'd0,
        ACT_CLEAR    = 3'd1,
        ACT_APPEND   = 3'd2,
        ACT_READ_OLD = 3'd3,
        ACT_READ_NEW = 3'd4
    } action_t;

    // Input word, first field in the highest bits.
    typedef struct packed {
        logic              restored_meta_slot;
        logic [SEQ_W-1:0]  restored_meta_seq;
        logic [SEQ_W-1:0]  restored_next_seq;
        logic [SLOT_W-1:0] restored_count;
        logic [SLOT_W-1:0] position;
    } in_item_t;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic [SEQ_W-1:0]  log_next_seq;
        logic [SLOT_W-1:0] log_count;
        logic [SLOT_W-1:0] log_write_ptr;
        logic [SEQ_W-1:0]  meta_seq_out;
        logic              meta_slot_out;
        logic              save_meta;
        logic [SEQ_W-1:0]  record_seq;
        logic [SLOT_W-1:0] phys_slot;
        logic              erase_all;
        logic [SEC_W-1:0]  erase_sector;
        logic              erase_sector_valid;
        logic              status;
    } out_item_t;

    localparam int IN_ITEM_W   = $bits(in_item_t);
    localparam int OUT_ITEM_W  = $bits(out_item_t);
    localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

    function automatic logic [SECX_W-1:0] sector_of(input logic [SLOT_W-1:0] slot);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(slot) * PROD_W'(RECORD_BYTES);
        return SECX_W'(prod / SECTOR_BYTES);
    endfunction

endpackage

// ===== hw/rtl/flash_ring_log_index_manager.sv =====
`timescale 1ns / 1ps
// Index manager for a circular record log in sector-erased flash, with the erased-sector
// bitmap kept in a one-bit synchronous memory. Depends on frlim_pkg and the assertion header.
//
// An append, a read or an unused action code passes through IDLE and EXEC: the word is
// accepted in IDLE (an append reads the erased bit of its target sector from the bitmap
// memory there), and in EXEC the result is written to the output register, together with the
// bitmap write-back. EXEC waits while the previous result has not been taken. Load and
// clear rewrite the whole bitmap afterwards, one sector per cycle through the single write
// port, so they hold off the next word until that sweep ends. After reset a sweep runs that
// marks every sector as not erased, and the first word is accepted only once it has ended.
module flash_ring_log_index_manager (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // position, restored_count, restored_next_seq, restored_meta_seq, restored_meta_slot
    input  logic [frlim_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [frlim_pkg::ACT_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, erase_sector_valid, erase_sector, erase_all, phys_slot, record_seq,
    // save_meta, meta_slot_out, meta_seq_out, log_write_ptr, log_count, log_next_seq
    output logic [frlim_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import frlim_pkg::*;

    `include "flash_ring_log_index_manager_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    localparam logic [SLOT_W-1:0] CAP_L   = SLOT_W'(CAPACITY);
    localparam logic [SLOT_W:0]   CAP_X   = (SLOT_W + 1)'(CAPACITY);
    localparam logic [SECX_W-1:0] SCNT_X  = SECX_W'(SECTOR_COUNT);
    localparam logic [SEC_W-1:0]  SEC_LAST = SEC_W'(SECTOR_COUNT - 1);

    state_t            state_reg, state_next;
    logic [SEC_W-1:0]  sweep_idx_reg, sweep_idx_next;
    logic [SECX_W-1:0] sweep_lo_reg, sweep_lo_next;

    logic [SLOT_W-1:0] wp_reg, wp_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [SEQ_W-1:0]  nseq_reg, nseq_next;
    logic [SEQ_W-1:0]  mseq_reg, mseq_next;
    logic              mslot_reg, mslot_next;

    action_t           act_reg;
    in_item_t          item_reg;
    out_item_t         res_reg, res_next;
    logic              m_tvalid_reg;

    logic              erased_mem [SECTOR_COUNT];
    logic              rd_bit_reg;
    logic              rd_en;
    logic              mem_we;
    logic [SEC_W-1:0]  mem_waddr;
    logic              mem_wdata;

    logic              accept;
    logic              exec_fire;
    logic              app_we;
    logic [SECX_W-1:0] app_sec;
    logic [SECX_W-1:0] last_sec;
    logic              live;
    logic              load_bad;
    logic [SLOT_W-1:0] last_slot;
    logic [SLOT_W-1:0] latest;
    logic [SLOT_W-1:0] old_base;
    logic [SLOT_W:0]   old_sum;
    logic [SLOT_W-1:0] rd_old;
    logic [SLOT_W-1:0] rd_new;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TDATA_W'(res_reg);

    // The write pointer does not move between accept and execute, so the bitmap
    // read issued at accept already addresses the sector that the append targets.
    assign app_sec = sector_of(wp_reg);
    assign rd_en   = accept && (action_t'(s_tuser) == ACT_APPEND);

    // A sector holds live records when its first slot lies below the record count.
    assign live = (cnt_reg != '0) &&
                  ((cnt_reg >= CAP_L) || (sector_of(cnt_reg - SLOT_W'(1)) >= app_sec));

    assign latest   = (wp_reg == '0) ? (CAP_L - SLOT_W'(1)) : (wp_reg - SLOT_W'(1));
    assign old_base = (cnt_reg < CAP_L) ? '0 : wp_reg;
    assign old_sum  = {1'b0, old_base} + {1'b0, item_reg.position};
    assign rd_old   = (old_sum >= CAP_X) ? SLOT_W'(old_sum - CAP_X) : SLOT_W'(old_sum);
    assign rd_new   = (latest >= item_reg.position)
                    ? (latest - item_reg.position)
                    : SLOT_W'({1'b0, latest} + CAP_X - {1'b0, item_reg.position});

    assign load_bad  = (item_reg.position >= CAP_L) || (item_reg.restored_count > CAP_L) ||
                       (item_reg.restored_next_seq == '0) || (item_reg.restored_next_seq == '1);
    assign last_slot = (item_reg.position == '0) ? (CAP_L - SLOT_W'(1))
                                                 : (item_reg.position - SLOT_W'(1));
    assign last_sec  = sector_of(last_slot);

    always_comb begin
        wp_next       = wp_reg;
        cnt_next      = cnt_reg;
        nseq_next     = nseq_reg;
        mseq_next     = mseq_reg;
        mslot_next    = mslot_reg;
        sweep_lo_next = sweep_lo_reg;
        res_next      = '0;
        app_we        = 1'b0;
        case (act_reg)
            ACT_LOAD: begin
                if (load_bad) begin
                    wp_next       = '0;
                    cnt_next      = '0;
                    nseq_next     = SEQ_W'(1);
                    mseq_next     = SEQ_W'(1);
                    mslot_next    = 1'b1;
                    res_next.save_meta = 1'b1;
                    sweep_lo_next = '0;
                end else begin
                    wp_next    = item_reg.position;
                    cnt_next   = item_reg.restored_count;
                    nseq_next  = item_reg.restored_next_seq;
                    mseq_next  = item_reg.restored_meta_seq;
                    mslot_next = item_reg.restored_meta_slot;
                    if (item_reg.restored_count == '0) begin
                        sweep_lo_next = '0;
                    end else if (item_reg.restored_count < CAP_L) begin
                        sweep_lo_next = last_sec + SECX_W'(1);
                    end else begin
                        sweep_lo_next = SCNT_X;
                    end
                end
            end
            ACT_CLEAR: begin
                wp_next       = '0;
                cnt_next      = '0;
                nseq_next     = SEQ_W'(1);
                mseq_next     = SEQ_W'(1);
                mslot_next    = 1'b1;
                sweep_lo_next = '0;
                res_next.erase_all = 1'b1;
                res_next.save_meta = 1'b1;
            end
            ACT_APPEND: begin
                if (app_sec >= SCNT_X) begin
                    res_next.status = 1'b1;
                end else begin
                    app_we = 1'b1;
                    if (!rd_bit_reg && !live) begin
                        res_next.erase_sector_valid = 1'b1;
                        res_next.erase_sector       = app_sec[SEC_W-1:0];
                    end
                    res_next.phys_slot  = wp_reg;
                    res_next.record_seq = nseq_reg;
                    res_next.save_meta  = 1'b1;
                    wp_next    = ((SLOT_W + 1)'(wp_reg) + (SLOT_W + 1)'(1) >= CAP_X)
                               ? '0 : (wp_reg + SLOT_W'(1));
                    cnt_next   = (cnt_reg < CAP_L) ? (cnt_reg + SLOT_W'(1)) : cnt_reg;
                    nseq_next  = nseq_reg + SEQ_W'(1);
                    mseq_next  = mseq_reg + SEQ_W'(1);
                    mslot_next = ~mslot_reg;
                end
            end
            ACT_READ_OLD: begin
                if (item_reg.position >= cnt_reg) begin
                    res_next.status = 1'b1;
                end else begin
                    res_next.phys_slot = rd_old;
                end
            end
            ACT_READ_NEW: begin
                if (item_reg.position >= cnt_reg) begin
                    res_next.status = 1'b1;
                end else begin
                    res_next.phys_slot = rd_new;
                end
            end
            default: begin
            end
        endcase
        res_next.meta_slot_out = mslot_next;
        res_next.meta_seq_out  = mseq_next;
        res_next.log_write_ptr = wp_next;
        res_next.log_count     = cnt_next;
        res_next.log_next_seq  = nseq_next;
    end

    always_comb begin
        state_next     = state_reg;
        sweep_idx_next = sweep_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    if (act_reg == ACT_LOAD || act_reg == ACT_CLEAR) begin
                        state_next     = ST_SWEEP;
                        sweep_idx_next = '0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                sweep_idx_next = sweep_idx_reg + SEC_W'(1);
                if (sweep_idx_reg == SEC_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sweep marks every sector at or above the threshold as erased; an append clears its bit.
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_idx_reg;
            mem_wdata = ({1'b0, sweep_idx_reg} >= sweep_lo_reg);
        end else begin
            mem_we    = exec_fire && app_we;
            mem_waddr = app_sec[SEC_W-1:0];
            mem_wdata = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            erased_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_bit_reg <= erased_mem[app_sec[SEC_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= action_t'(s_tuser);
            item_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
        end
        if (exec_fire) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_idx_reg <= '0;
            sweep_lo_reg  <= SCNT_X;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            nseq_reg      <= SEQ_W'(1);
            mseq_reg      <= '0;
            mslot_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            if (exec_fire) begin
                sweep_lo_reg <= sweep_lo_next;
                wp_reg       <= wp_next;
                cnt_reg      <= cnt_next;
                nseq_reg     <= nseq_next;
                mseq_reg     <= mseq_next;
                mslot_reg    <= mslot_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `FRLIM_ASSERT(a_count_bound, cnt_reg <= CAP_L, "record count exceeds capacity")
    `FRLIM_ASSERT(a_wptr_bound, wp_reg < CAP_L, "write pointer beyond capacity")
    `FRLIM_ASSERT(a_erase_sector, (m_tvalid_reg && res_reg.erase_sector_valid) |-> (SECX_W'(res_reg.erase_sector) == sector_of(res_reg.phys_slot)), "erase sector does not hold the written slot")
    `FRLIM_ASSERT(a_erase_saves, (m_tvalid_reg && res_reg.erase_sector_valid) |-> (res_reg.save_meta && !res_reg.status), "erase request without metadata save")
    `FRLIM_ASSERT(a_sweep_runs, (state_reg == ST_SWEEP && sweep_idx_reg != '0) |-> ($past(state_reg) == ST_SWEEP), "bitmap sweep entered midway")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flash_ring_log_index_manager: directed words, then random
// load/clear sessions of appends and reads, with stalls on both stream ports.
// Depends on frlim_pkg and the RTL of the block; reads no files.
module tb_top;
    import frlim_pkg::*;

    localparam longint CAP          = longint'(CAPACITY);
    localparam longint SEC_BYTES    = longint'(SECTOR_BYTES);
    localparam longint REC_BYTES    = longint'(RECORD_BYTES);
    localparam int unsigned POS_MAX = (1 << SLOT_W) - 1;
    localparam int STALL_LIMIT      = 40000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int HOLD_CYCLES      = 400;

    // Action codes the block accepts but treats as no-ops.
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_len = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    // Shadow copy of the log index state.
    logic [SLOT_W-1:0] shadow_wp = '0;
    logic [SLOT_W-1:0] shadow_count = '0;
    logic [SEQ_W-1:0]  shadow_next_seq = 1;
    logic [SEQ_W-1:0]  shadow_meta_seq = '0;
    logic              shadow_meta_slot = 1'b0;
    bit                shadow_erased [SECTOR_COUNT];

    out_item_t pending_results[$];

    flash_ring_log_index_manager uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint slot_sector(input longint slot);
        return (slot * REC_BYTES) / SEC_BYTES;
    endfunction

    function automatic void restore_defaults();
        shadow_wp = '0;
        shadow_count = '0;
        shadow_next_seq = 1;
        shadow_meta_seq = '0;
        shadow_meta_slot = 1'b0;
    endfunction

    function automatic void bump_meta();
        shadow_meta_seq = shadow_meta_seq + 1'b1;
        shadow_meta_slot = ~shadow_meta_slot;
    endfunction

    // Computes the result word of one accepted input word and advances the shadow state.
    function automatic out_item_t next_log_result(input logic [ACT_W-1:0] act,
                                                  input in_item_t it);
        out_item_t r;
        longint sec, s, lo, hi, p, latest, last;
        bit live;
        r = '0;
        case (act)
            ACT_LOAD: begin
                if (longint'(it.position) >= CAP || longint'(it.restored_count) > CAP
                        || it.restored_next_seq == '0 || it.restored_next_seq == '1) begin
                    restore_defaults();
                    bump_meta();
                    r.save_meta = 1'b1;
                end else begin
                    shadow_wp = it.position;
                    shadow_count = it.restored_count;
                    shadow_next_seq = it.restored_next_seq;
                    shadow_meta_seq = it.restored_meta_seq;
                    shadow_meta_slot = it.restored_meta_slot;
                end
                // An empty log is erased everywhere; a partial one above its last record.
                for (s = 0; s < SECTOR_COUNT; s++)
                    shadow_erased[s] = (shadow_count == 0);
                if (shadow_count != 0 && longint'(shadow_count) < CAP) begin
                    last = (shadow_wp == 0) ? CAP - 1 : longint'(shadow_wp) - 1;
                    for (s = slot_sector(last) + 1; s < SECTOR_COUNT; s++)
                        shadow_erased[s] = 1'b1;
                end
            end
            ACT_CLEAR: begin
                r.erase_all = 1'b1;
                restore_defaults();
                bump_meta();
                r.save_meta = 1'b1;
                for (s = 0; s < SECTOR_COUNT; s++)
                    shadow_erased[s] = 1'b1;
            end
            ACT_APPEND: begin
                sec = slot_sector(longint'(shadow_wp));
                if (sec >= SECTOR_COUNT) begin
                    r.status = 1'b1;
                end else begin
                    // Live records of a log that has not wrapped sit in slots 0 .. count-1.
                    live = 1'b0;
                    if (shadow_count != 0) begin
                        lo = (sec * SEC_BYTES + REC_BYTES - 1) / REC_BYTES;
                        hi = ((sec + 1) * SEC_BYTES - 1) / REC_BYTES;
                        if (hi > CAP - 1)
                            hi = CAP - 1;
                        if (lo <= hi)
                            live = (longint'(shadow_count) >= CAP)
                                || (lo <= longint'(shadow_count) - 1);
                    end
                    if (!shadow_erased[sec] && !live) begin
                        r.erase_sector_valid = 1'b1;
                        r.erase_sector = SEC_W'(sec);
                    end
                    r.phys_slot = shadow_wp;
                    r.record_seq = shadow_next_seq;
                    r.save_meta = 1'b1;
                    shadow_erased[sec] = 1'b0;
                    if (longint'(shadow_wp) + 1 >= CAP)
                        shadow_wp = '0;
                    else
                        shadow_wp = shadow_wp + 1'b1;
                    if (longint'(shadow_count) < CAP)
                        shadow_count = shadow_count + 1'b1;
                    shadow_next_seq = shadow_next_seq + 1'b1;
                    bump_meta();
                end
            end
            ACT_READ_OLD, ACT_READ_NEW: begin
                if (it.position >= shadow_count) begin
                    r.status = 1'b1;
                end else if (act == ACT_READ_OLD) begin
                    p = longint'(it.position);
                    if (longint'(shadow_count) >= CAP)
                        p = p + longint'(shadow_wp);
                    if (p >= CAP)
                        p = p - CAP;
                    r.phys_slot = SLOT_W'(p);
                end else begin
                    latest = (shadow_wp == 0) ? CAP - 1 : longint'(shadow_wp) - 1;
                    if (latest >= longint'(it.position))
                        p = latest - longint'(it.position);
                    else
                        p = CAP - (longint'(it.position) - latest);
                    r.phys_slot = SLOT_W'(p);
                end
            end
            default: ;
        endcase
        r.meta_slot_out = shadow_meta_slot;
        r.meta_seq_out = shadow_meta_seq;
        r.log_write_ptr = shadow_wp;
        r.log_count = shadow_count;
        r.log_next_seq = shadow_next_seq;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_word(input logic [ACT_W-1:0] act, input in_item_t item);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = IN_TDATA_W'(item);
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(next_log_result(act, item));
    endtask

    // Fields the action does not use carry random noise.
    task automatic send_op(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] pos);
        in_item_t it;
        it.position = pos;
        it.restored_count = SLOT_W'($urandom);
        it.restored_next_seq = $urandom;
        it.restored_meta_seq = $urandom;
        it.restored_meta_slot = 1'($urandom_range(1));
        send_word(act, it);
    endtask

    task automatic send_load(input logic [SLOT_W-1:0] wp, input logic [SLOT_W-1:0] cnt,
                             input logic [SEQ_W-1:0] nseq, input logic [SEQ_W-1:0] mseq,
                             input logic slot);
        in_item_t it;
        it.position = wp;
        it.restored_count = cnt;
        it.restored_next_seq = nseq;
        it.restored_meta_seq = mseq;
        it.restored_meta_slot = slot;
        send_word(ACT_LOAD, it);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_len != 0) begin
            m_tready = 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        out_item_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_ITEM_W-1:0];
            if (pending_results.size() == 0) begin
                report("result word with nothing expected", 32'(got.phys_slot), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report("status", 32'(got.status), 32'(want.status));
                if (got.erase_sector_valid !== want.erase_sector_valid)
                    report("erase_sector_valid", 32'(got.erase_sector_valid),
                           32'(want.erase_sector_valid));
                if (got.erase_sector !== want.erase_sector)
                    report("erase_sector", 32'(got.erase_sector), 32'(want.erase_sector));
                if (got.erase_all !== want.erase_all)
                    report("erase_all", 32'(got.erase_all), 32'(want.erase_all));
                if (got.phys_slot !== want.phys_slot)
                    report("phys_slot", 32'(got.phys_slot), 32'(want.phys_slot));
                if (got.record_seq !== want.record_seq)
                    report("record_seq", got.record_seq, want.record_seq);
                if (got.save_meta !== want.save_meta)
                    report("save_meta", 32'(got.save_meta), 32'(want.save_meta));
                if (got.meta_slot_out !== want.meta_slot_out)
                    report("meta_slot_out", 32'(got.meta_slot_out), 32'(want.meta_slot_out));
                if (got.meta_seq_out !== want.meta_seq_out)
                    report("meta_seq_out", got.meta_seq_out, want.meta_seq_out);
                if (got.log_write_ptr !== want.log_write_ptr)
                    report("log_write_ptr", 32'(got.log_write_ptr), 32'(want.log_write_ptr));
                if (got.log_count !== want.log_count)
                    report("log_count", 32'(got.log_count), 32'(want.log_count));
                if (got.log_next_seq !== want.log_next_seq)
                    report("log_next_seq", got.log_next_seq, want.log_next_seq);
            end
        end
    end

    // Load and clear sweep the whole bitmap, so the limit sits well above the length of that sweep.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("** flash_ring_log_index_manager: FAILED **");
        $finish;
    end

    task automatic test_empty_log();
        send_op(ACT_READ_OLD, '0);
        send_op(ACT_READ_NEW, '0);
        send_op(ACT_APPEND, '0);
        send_op(ACT_APPEND, '0);
        send_op(ACT_READ_NEW, '0);
        send_op(ACT_READ_OLD, SLOT_W'(1));
        send_op(ACT_READ_OLD, SLOT_W'(2));
    endtask

    task automatic test_unused_codes();
        for (int a = int'(ACT_SPARE_LO); a <= int'(ACT_SPARE_HI); a++)
            send_op(ACT_W'(a), SLOT_W'($urandom));
    endtask

    task automatic test_clear();
        send_op(ACT_CLEAR, SLOT_W'($urandom));
        send_op(ACT_APPEND, '0);
    endtask

    // Full ring at its last slot: pointer, record and metadata sequences all wrap.
    task automatic test_full_ring_wrap();
        send_load(SLOT_W'(CAP - 1), SLOT_W'(CAP), 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
        send_op(ACT_APPEND, '0);
        send_op(ACT_APPEND, '0);
        send_op(ACT_READ_OLD, SLOT_W'(CAP - 1));
        send_op(ACT_READ_NEW, SLOT_W'(CAP - 1));
        send_op(ACT_READ_NEW, SLOT_W'(POS_MAX));
    endtask

    task automatic test_bad_load();
        send_load(SLOT_W'(POS_MAX), SLOT_W'(5), 32'd9, 32'h1234_5678, 1'b1);
        send_load(SLOT_W'(7), SLOT_W'(POS_MAX), 32'd9, 32'hFFFF_FFFF, 1'b0);
        send_load(SLOT_W'(7), SLOT_W'(3), '0, '0, 1'b1);
        send_load(SLOT_W'(7), SLOT_W'(3), 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b0);
    endtask

    // A few records at the start, pointer far ahead: its sector is neither erased nor live.
    task automatic test_sector_erase();
        send_load(SLOT_W'(3000), SLOT_W'(3), 32'd100, 32'd7, 1'b0);
        send_op(ACT_APPEND, '0);
        send_load(SLOT_W'(5), SLOT_W'(0), 32'd2, 32'd0, 1'b1);
        send_op(ACT_APPEND, '0);
    endtask

    task automatic test_output_backpressure();
        int i;
        @(posedge aclk);
        hold_len = HOLD_CYCLES;
        for (i = 0; i < 24; i++)
            send_op((i % 3 == 2) ? ACT_READ_OLD : ACT_APPEND, SLOT_W'(i));
    endtask

    // Sessions: a load (mostly good), a clear or neither, then a run of appends, reads and unused codes.
    task automatic test_random_traffic(input int n_items);
        int sent, r, run;
        longint wp, cnt, k;
        logic [SEQ_W-1:0] nseq;
        logic [ACT_W-1:0] act;
        logic [SLOT_W-1:0] pos;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 80) begin
                case ($urandom_range(3))
                    0: wp = longint'($urandom_range(CAPACITY - 1, 0));
                    1: wp = longint'($urandom_range(40, 0));
                    2: wp = CAP - 1 - longint'($urandom_range(40, 0));
                    default: begin
                        // At or just below the first slot of some sector.
                        k = longint'($urandom_range(SECTOR_COUNT - 1, 1));
                        wp = (k * SEC_BYTES + REC_BYTES - 1) / REC_BYTES
                           - longint'($urandom_range(3, 0));
                    end
                endcase
                case ($urandom_range(5))
                    0: cnt = 0;
                    1: cnt = longint'($urandom_range(50, 1));
                    2: cnt = wp;
                    3: cnt = CAP;
                    4: cnt = CAP - longint'($urandom_range(40, 1));
                    default: cnt = longint'($urandom_range(CAPACITY, 0));
                endcase
                if ($urandom_range(3) == 0)
                    nseq = 32'hFFFF_FFFE - $urandom_range(8, 0);
                else
                    nseq = $urandom_range(32'hFFFF_FFFE, 1);
                if (r >= 68) begin
                    case ($urandom_range(3))
                        0: wp = longint'($urandom_range(POS_MAX, CAPACITY));
                        1: cnt = longint'($urandom_range(POS_MAX, CAPACITY + 1));
                        2: nseq = '0;
                        default: nseq = '1;
                    endcase
                end
                send_load(SLOT_W'(wp), SLOT_W'(cnt), nseq, $urandom,
                          1'($urandom_range(1)));
                sent++;
            end else if (r < 94) begin
                send_op(ACT_CLEAR, SLOT_W'($urandom));
                sent++;
            end
            run = $urandom_range(40, 10);
            repeat (run) begin
                r = $urandom_range(99);
                if (r < 48)
                    act = ACT_APPEND;
                else if (r < 72)
                    act = ACT_READ_OLD;
                else if (r < 96)
                    act = ACT_READ_NEW;
                else
                    act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
                if (shadow_count != 0 && $urandom_range(9) != 0) begin
                    case ($urandom_range(3))
                        0: pos = '0;
                        1: pos = shadow_count - 1'b1;
                        default: pos = SLOT_W'($urandom_range(shadow_count - 1, 0));
                    endcase
                end else begin
                    pos = SLOT_W'($urandom_range(POS_MAX, 0));
                end
                send_op(act, pos);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 79;
        test_empty_log();
        test_unused_codes();
        test_clear();
        test_full_ring_wrap();
        test_bad_load();
        test_sector_erase();
        test_random_traffic(430);

        tx_idle_pct = 79;
        rx_idle_pct = 6;
        test_random_traffic(450);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(420);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("** flash_ring_log_index_manager: PASSED **");
        else
            $display("** flash_ring_log_index_manager: FAILED **");
        $finish;
    end
endmodule
